// ===== hw/rtl/shc_pkg.sv =====
// Package: constants, codes, types and helper functions for the stereo matcher.
`timescale 1ns / 1ps
`default_nettype none
package shc_pkg;

	localparam int MAX_POINTS = 512;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int DESC_BITS  = 256;
	localparam int DESC_W     = 256;
	localparam int COORD_W    = 16;
	localparam int ENTRY_W    = DESC_W + 2 * COORD_W;
	localparam int DIST_W     = 9;
	localparam int PC_W       = 7;
	localparam int DISP_W     = 8;
	localparam int ROW_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [DISP_W-1:0] MAX_DISP_RESET = 8'd255;
	localparam logic [ROW_W-1:0]  MAX_ROW_RESET  = 4'd1;

	localparam logic [DESC_W-1:0] DESC_MASK = {DESC_W{1'b1}} >> (DESC_W - DESC_BITS);

	typedef enum logic [1:0] {
		OP_LOAD_LEFT  = 2'd0,
		OP_LOAD_RIGHT = 2'd1,
		OP_QUERY      = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DISP = 1'b0,
		REG_MAX_ROW  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QLATCH,
		ST_SCAN,
		ST_DRAIN,
		ST_BLATCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             load_query;
		logic             fwd;
		logic             cand_valid;
		logic [IDX_W-1:0] cand_idx;
	} scan_ctl_t;

	typedef struct packed {
		logic              busy;
		logic              found;
		logic [IDX_W-1:0]  best_idx;
		logic [DIST_W-1:0] best_dist;
	} scan_sts_t;

	function automatic logic [PC_W-1:0] popcount64(input logic [63:0] v);
		logic [PC_W-1:0] s;
		s = '0;
		for (int i = 0; i < 64; i++) begin
			s = s + PC_W'(v[i]);
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/shc_if.sv =====
// Interfaces: input item, result item and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none
interface shc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [8:0]  point_index;
	logic [15:0] x_pos;
	logic [15:0] y_pos;
	logic [63:0] desc_word0;
	logic [63:0] desc_word1;
	logic [63:0] desc_word2;
	logic [63:0] desc_word3;
	modport source(output valid, operation, point_index, x_pos, y_pos,
		desc_word0, desc_word1, desc_word2, desc_word3, input ready);
	modport sink(input valid, operation, point_index, x_pos, y_pos,
		desc_word0, desc_word1, desc_word2, desc_word3, output ready);
endinterface

interface shc_result_if;
	logic       valid;
	logic       ready;
	logic       matched;
	logic [8:0] queried_index;
	logic [8:0] partner_index;
	logic [8:0] hamming_distance;
	modport source(output valid, matched, queried_index, partner_index,
		hamming_distance, input ready);
	modport sink(input valid, matched, queried_index, partner_index,
		hamming_distance, output ready);
endinterface

interface shc_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [7:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/stereo_hamming_cross_check_matcher.sv =====
// Top level: point stores, query sequencer and result register of the stereo matcher.
// Loads are accepted back to back while idle.
// During a query one candidate per cycle goes through the shared distance unit,
// first over the right store, then, if the right store gave a candidate, over the left.
// A query of an unloaded slot skips the scan and returns an unmatched result.
// Reset (arst_n, asynchronous, active low) clears both point counts and restores
// max_disparity to 255 and max_row_error to 1; point stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module stereo_hamming_cross_check_matcher (
	input wire logic   clk,
	input wire logic   arst_n,
	shc_item_if.sink   item,
	shc_result_if.source result,
	shc_cfg_if.sink    cfg
);
	import shc_pkg::*;

	state_t state_q, state_d;

	logic [DISP_W-1:0]  max_disp_q;
	logic [ROW_W-1:0]   max_row_q;
	logic [CNT_W-1:0]   left_count_q, right_count_q;

	logic               item_acc;
	op_t                op;
	logic [IDX_W-1:0]   idx;
	logic               idx_ok;
	logic [CNT_W-1:0]   cnt_upd_l, cnt_upd_r;
	logic [ENTRY_W-1:0] wentry;

	logic               l_we, r_we, l_re, r_re;
	logic [IDX_W-1:0]   l_raddr, r_raddr;
	logic [ENTRY_W-1:0] l_rdata, r_rdata;

	logic [IDX_W-1:0]   qidx_q;
	logic [CNT_W-1:0]   j_q, lim_q;
	logic               back_q;
	logic [IDX_W-1:0]   r_q;
	logic [DIST_W-1:0]  fd_q;
	logic               res_match_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;

	logic               issue, start_fwd, start_back, take_best, set_res, set_res_val;
	logic               out_load;

	scan_ctl_t          ctl;
	scan_sts_t          sts;
	logic [ENTRY_W-1:0] query_data;

	logic               out_valid_q, out_match_q;
	logic [8:0]         out_qidx_q, out_pidx_q, out_dist_q;

	// decode the input item
	assign item_acc = item.valid && item.ready;
	assign op       = op_t'(item.operation);
	assign idx      = IDX_W'(item.point_index);
	assign idx_ok   = (CNT_W'(item.point_index) < CNT_W'(MAX_POINTS));
	assign wentry   = {item.desc_word3, item.desc_word2, item.desc_word1, item.desc_word0,
		item.y_pos, item.x_pos};
	assign l_we     = item_acc && (op == OP_LOAD_LEFT) && idx_ok;
	assign r_we     = item_acc && (op == OP_LOAD_RIGHT) && idx_ok;

	// count after a load: slot 0 restarts the side
	assign cnt_upd_l = (idx == '0) ? CNT_W'(1) :
		((CNT_W'(idx) + CNT_W'(1) > left_count_q) ? CNT_W'(idx) + CNT_W'(1) : left_count_q);
	assign cnt_upd_r = (idx == '0) ? CNT_W'(1) :
		((CNT_W'(idx) + CNT_W'(1) > right_count_q) ? CNT_W'(idx) + CNT_W'(1) : right_count_q);

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_disp_q <= MAX_DISP_RESET;
			max_row_q  <= MAX_ROW_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (reg_idx_t'(cfg.index))
				REG_MAX_DISP: max_disp_q <= cfg.data;
				REG_MAX_ROW:  max_row_q  <= cfg.data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// point counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q  <= '0;
			right_count_q <= '0;
		end else begin
			if (l_we) begin
				left_count_q <= cnt_upd_l;
			end
			if (r_we) begin
				right_count_q <= cnt_upd_r;
			end
		end
	end

	// point stores: coordinates and descriptor per slot
	shc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_left_ram (
		.clk  (clk),
		.we   (l_we),
		.waddr(idx),
		.wdata(wentry),
		.re   (l_re),
		.raddr(l_raddr),
		.rdata(l_rdata)
	);

	shc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_right_ram (
		.clk  (clk),
		.we   (r_we),
		.waddr(idx),
		.wdata(wentry),
		.re   (r_re),
		.raddr(r_raddr),
		.rdata(r_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d     = state_q;
		item.ready  = 1'b0;
		l_re        = 1'b0;
		r_re        = 1'b0;
		l_raddr     = j_q[IDX_W-1:0];
		r_raddr     = j_q[IDX_W-1:0];
		issue       = 1'b0;
		start_fwd   = 1'b0;
		start_back  = 1'b0;
		take_best   = 1'b0;
		set_res     = 1'b0;
		set_res_val = 1'b0;
		out_load    = 1'b0;
		query_data  = back_q ? r_rdata : l_rdata;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item_acc && op == OP_QUERY) begin
					if (idx_ok && CNT_W'(item.point_index) < left_count_q) begin
						l_re    = 1'b1;
						l_raddr = idx;
						state_d = ST_QLATCH;
					end else begin
						set_res = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_QLATCH: begin
				query_data = l_rdata;
				start_fwd  = 1'b1;
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				if (j_q < lim_q) begin
					issue = 1'b1;
					l_re  = back_q;
					r_re  = !back_q;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_vld_s1 && !sts.busy) begin
					if (!back_q) begin
						if (sts.found) begin
							r_re      = 1'b1;
							r_raddr   = sts.best_idx;
							take_best = 1'b1;
							state_d   = ST_BLATCH;
						end else begin
							set_res = 1'b1;
							state_d = ST_DONE;
						end
					end else begin
						set_res     = 1'b1;
						set_res_val = sts.found && (sts.best_idx == qidx_q);
						state_d     = ST_DONE;
					end
				end
			end
			ST_BLATCH: begin
				query_data = r_rdata;
				start_back = 1'b1;
				state_d    = ST_SCAN;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			back_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (start_fwd) begin
				back_q <= 1'b0;
			end else if (start_back) begin
				back_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= j_q[IDX_W-1:0];
		if (item_acc && op == OP_QUERY) begin
			qidx_q <= idx;
		end
		if (start_fwd) begin
			j_q   <= '0;
			lim_q <= right_count_q;
		end else if (start_back) begin
			j_q   <= '0;
			lim_q <= left_count_q;
		end else if (issue) begin
			j_q <= j_q + CNT_W'(1);
		end
		if (take_best) begin
			r_q  <= sts.best_idx;
			fd_q <= sts.best_dist;
		end
		if (set_res) begin
			res_match_q <= set_res_val;
		end
	end

	// shared distance unit
	assign ctl.load_query = start_fwd || start_back;
	assign ctl.fwd        = !back_q;
	assign ctl.cand_valid = rd_vld_s1;
	assign ctl.cand_idx   = rd_idx_s1;

	shc_scan_unit u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.query_data(query_data),
		.cand_data (back_q ? l_rdata : r_rdata),
		.max_disp  (max_disp_q),
		.max_row   (max_row_q),
		.sts       (sts)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_match_q <= res_match_q;
			out_qidx_q  <= 9'(qidx_q);
			out_pidx_q  <= res_match_q ? 9'(r_q) : 9'd0;
			out_dist_q  <= res_match_q ? fd_q : 9'd0;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.matched          = out_match_q;
	assign result.queried_index    = out_qidx_q;
	assign result.partner_index    = out_pidx_q;
	assign result.hamming_distance = out_dist_q;

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (state_q == ST_IDLE))
		else $error("input ready outside idle");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.matched) |->
		(result.partner_index == 9'd0 && result.hamming_distance == 9'd0))
		else $error("unmatched result carries partner or distance");

	a_back_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLATCH) |-> $past(sts.found))
		else $error("back search started without a forward candidate");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(left_count_q <= CNT_W'(MAX_POINTS)) && (right_count_q <= CNT_W'(MAX_POINTS)))
		else $error("point count beyond store depth");
endmodule
`default_nettype wire

// ===== hw/rtl/shc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module shc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/shc_scan_unit.sv =====
// Shared window check, Hamming distance and best-candidate tracking unit.
`timescale 1ns / 1ps
`default_nettype none
module shc_scan_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire shc_pkg::scan_ctl_t         ctl,
	input  wire logic [shc_pkg::ENTRY_W-1:0] query_data,
	input  wire logic [shc_pkg::ENTRY_W-1:0] cand_data,
	input  wire logic [shc_pkg::DISP_W-1:0]  max_disp,
	input  wire logic [shc_pkg::ROW_W-1:0]   max_row,
	output      shc_pkg::scan_sts_t         sts
);
	import shc_pkg::*;

	logic [ENTRY_W-1:0] q_q;
	logic [COORD_W-1:0] qx, qy, cx, cy, dy, dmax16, rmax16;
	logic [COORD_W:0]   d;
	logic [DESC_W-1:0]  diff;
	logic               in_win;

	logic               v_s2;
	logic               win_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [PC_W-1:0]    pc_s2 [4];

	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic [DIST_W-1:0]  cand_dist;

	// hold the query point
	always_ff @(posedge clk) begin
		if (ctl.load_query) begin
			q_q <= query_data;
		end
	end

	// window check on the candidate
	always_comb begin
		qx     = q_q[COORD_W-1:0];
		qy     = q_q[2*COORD_W-1:COORD_W];
		cx     = cand_data[COORD_W-1:0];
		cy     = cand_data[2*COORD_W-1:COORD_W];
		d      = ctl.fwd ? ({1'b0, qx} - {1'b0, cx}) : ({1'b0, cx} - {1'b0, qx});
		dy     = (qy > cy) ? (qy - cy) : (cy - qy);
		dmax16 = COORD_W'({max_disp, 4'b0000});
		rmax16 = COORD_W'({max_row, 4'b0000});
		in_win = !d[COORD_W] && (d[COORD_W-1:0] <= dmax16) && (dy <= rmax16);
		diff   = (q_q[ENTRY_W-1:2*COORD_W] ^ cand_data[ENTRY_W-1:2*COORD_W]) & DESC_MASK;
	end

	// stage two: register word popcounts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctl.cand_valid;
		end
	end

	always_ff @(posedge clk) begin
		win_s2 <= in_win;
		idx_s2 <= ctl.cand_idx;
		for (int w = 0; w < 4; w++) begin
			pc_s2[w] <= popcount64(diff[64*w +: 64]);
		end
	end

	assign cand_dist = DIST_W'(pc_s2[0]) + DIST_W'(pc_s2[1]) + DIST_W'(pc_s2[2])
		+ DIST_W'(pc_s2[3]);

	// update the best candidate, lowest index wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.load_query) begin
			found_q <= 1'b0;
		end else if (v_s2 && win_s2 && (!found_q || cand_dist < best_dist_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.load_query && v_s2 && win_s2 && (!found_q || cand_dist < best_dist_q)) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= cand_dist;
		end
	end

	assign sts.busy      = v_s2;
	assign sts.found     = found_q;
	assign sts.best_idx  = best_idx_q;
	assign sts.best_dist = best_dist_q;
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the stereo Hamming matcher: random scenes, predicted matches, result checks.
`timescale 1ns / 1ps
module tb_top;
	import shc_pkg::*;

	localparam int CYCLE_LIMIT  = 1500000;
	localparam int TARGET_ITEMS = 580;
	localparam int SETTLE       = 40;

	typedef struct {
		logic       matched;
		logic [8:0] queried;
		logic [8:0] partner;
		logic [8:0] hdist;
	} match_t;

	// Predicts query results from its own copy of the point stores and window settings.
	class match_board;
		logic [15:0]  lx[512], ly[512], rx[512], ry[512];
		logic [255:0] ld[512], rd[512];
		int           lcnt, rcnt;
		int           disp_max, row_max;
		match_t       pending_q[$];
		int           errors;

		function new();
			lcnt = 0; rcnt = 0; disp_max = 255; row_max = 1; errors = 0;
		endfunction

		function void write_reg(reg_idx_t r, logic [7:0] v);
			if (r == REG_MAX_DISP) disp_max = v;
			else row_max = v[3:0];
		endfunction

		// Best candidate over one side's store; -1 when the window is empty.
		function int best_in_window(logic [15:0] qx, logic [15:0] qy, logic [255:0] qd,
				bit from_left, output int bd);
			int best, n, d, dy, hd;
			best = -1; bd = 0;
			n = from_left ? rcnt : lcnt;
			for (int j = 0; j < n; j++) begin
				if (from_left) begin
					d  = int'(qx) - int'(rx[j]);
					dy = int'(qy) - int'(ry[j]);
					hd = $countones(qd ^ rd[j]);
				end else begin
					d  = int'(lx[j]) - int'(qx);
					dy = int'(qy) - int'(ly[j]);
					hd = $countones(qd ^ ld[j]);
				end
				if (dy < 0) dy = -dy;
				if (d < 0 || d > disp_max * 16 || dy > row_max * 16) continue;
				if (best < 0 || hd < bd) begin
					best = j; bd = hd;
				end
			end
			return best;
		endfunction

		function void note_input(op_t op, logic [8:0] idx, logic [15:0] x, logic [15:0] y,
				logic [255:0] dsc);
			match_t e;
			int r, back, fd, bd;
			case (op)
				OP_LOAD_LEFT: begin
					lx[idx] = x; ly[idx] = y; ld[idx] = dsc;
					if (idx == 0) lcnt = 1;
					else if (idx + 1 > lcnt) lcnt = idx + 1;
				end
				OP_LOAD_RIGHT: begin
					rx[idx] = x; ry[idx] = y; rd[idx] = dsc;
					if (idx == 0) rcnt = 1;
					else if (idx + 1 > rcnt) rcnt = idx + 1;
				end
				OP_QUERY: begin
					e.matched = 0; e.queried = idx; e.partner = 0; e.hdist = 0;
					if (idx < lcnt) begin
						r = best_in_window(lx[idx], ly[idx], ld[idx], 1, fd);
						if (r >= 0) begin
							back = best_in_window(rx[r], ry[r], rd[r], 0, bd);
							if (back == idx) begin
								e.matched = 1; e.partner = 9'(r); e.hdist = 9'(fd);
							end
						end
					end
					pending_q = {pending_q, e};
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic m, logic [8:0] q, logic [8:0] p, logic [8:0] h);
			match_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result matched=%0d queried=%0d partner=%0d dist=%0d",
					$time, m, q, p, h);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (m !== e.matched) begin
				$display("%0t: matched exp %0d got %0d", $time, e.matched, m); errors++;
			end
			if (q !== e.queried) begin
				$display("%0t: queried_index exp %0d got %0d", $time, e.queried, q); errors++;
			end
			if (p !== e.partner) begin
				$display("%0t: partner_index exp %0d got %0d", $time, e.partner, p); errors++;
			end
			if (h !== e.hdist) begin
				$display("%0t: hamming_distance exp %0d got %0d", $time, e.hdist, h); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	shc_item_if   item();
	shc_result_if result();
	shc_cfg_if    cfg();

	stereo_hamming_cross_check_matcher i_dut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source), .cfg(cfg.sink)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	match_board board = new();
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_off = 0;
	int  sent_items = 0;
	int  cycle_count = 0;
	int  lcount_tb = 0, rcount_tb = 0;
	logic [15:0]  scene_x[64], scene_y[64];
	logic [255:0] scene_d[64];

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Check each result transaction and drive ready with stalls and hold-offs.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			board.check_result(result.matched, result.queried_index,
				result.partner_index, result.hamming_distance);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result.ready <= 0;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [255:0] rand_desc();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic send(op_t op, logic [8:0] idx, logic [15:0] x, logic [15:0] y,
			logic [255:0] dsc);
		while ($urandom_range(99) < send_idle_pct) begin
			item.valid <= 0;
			@(posedge clk);
		end
		item.valid       <= 1;
		item.operation   <= op;
		item.point_index <= idx;
		item.x_pos       <= x;
		item.y_pos       <= y;
		item.desc_word0  <= dsc[63:0];
		item.desc_word1  <= dsc[127:64];
		item.desc_word2  <= dsc[191:128];
		item.desc_word3  <= dsc[255:192];
		do @(posedge clk); while (!item.ready);
		board.note_input(op, idx, x, y, dsc);
		if (op != OP_NONE) sent_items++;
		if (op == OP_LOAD_LEFT)
			lcount_tb = (idx == 0) ? 1 : ((idx + 1 > lcount_tb) ? idx + 1 : lcount_tb);
		if (op == OP_LOAD_RIGHT)
			rcount_tb = (idx == 0) ? 1 : ((idx + 1 > rcount_tb) ? idx + 1 : rcount_tb);
	endtask

	task automatic write_reg(reg_idx_t r, logic [7:0] v);
		cfg.valid <= 1;
		cfg.index <= r;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(r, v);
		cfg.valid <= 0;
	endtask

	// Wait for the result queue to empty, then let the block settle before any register write.
	task automatic drain();
		item.valid <= 0;
		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Build a scene of nearby left/right points and query it; some points are pure noise.
	task automatic run_scene(int nl, int nr, int nq);
		logic [15:0]  x, y;
		logic [255:0] dsc;
		int k;
		for (int i = 0; i < nl; i++) begin
			if ($urandom_range(9) == 0) begin
				x = 16'($urandom); y = 16'($urandom); dsc = rand_desc();
			end else begin
				x = 16'($urandom_range(16 * 300, 16 * 1000));
				y = 16'($urandom_range(0, 16 * 12));
				dsc = rand_desc();
			end
			scene_x[i] = x; scene_y[i] = y; scene_d[i] = dsc;
			send(OP_LOAD_LEFT, 9'(i), x, y, dsc);
		end
		for (int j = 0; j < nr; j++) begin
			k = $urandom_range(nl - 1);
			if ($urandom_range(9) == 0) begin
				x = 16'($urandom); y = 16'($urandom); dsc = rand_desc();
			end else begin
				x = 16'(scene_x[k] - $urandom_range(0, 16 * 60));
				y = 16'(scene_y[k] + $urandom_range(0, 40) - 20);
				dsc = scene_d[k] ^ (rand_desc() & rand_desc() & rand_desc() & rand_desc());
			end
			send(OP_LOAD_RIGHT, 9'(j), x, y, dsc);
			if ($urandom_range(30) == 0)
				send(OP_NONE, 9'($urandom), 16'($urandom), 16'($urandom), rand_desc());
		end
		for (int q = 0; q < nq; q++) begin
			// Mostly loaded slots, some beyond the count, now and then an extension load.
			if ($urandom_range(15) == 0 && lcount_tb < 64)
				send(OP_LOAD_LEFT, 9'(lcount_tb), 16'($urandom), 16'($urandom), rand_desc());
			if ($urandom_range(7) == 0)
				send(OP_QUERY, 9'($urandom_range(lcount_tb, 511)), 0, 0, 0);
			else
				send(OP_QUERY, 9'($urandom_range(lcount_tb - 1)), 16'($urandom), 16'($urandom),
					rand_desc());
		end
	endtask

	initial begin
		logic [7:0] dv, rv;
		int scene;
		item.valid = 0; item.operation = OP_NONE; item.point_index = 0;
		item.x_pos = 0; item.y_pos = 0;
		item.desc_word0 = 0; item.desc_word1 = 0; item.desc_word2 = 0; item.desc_word3 = 0;
		cfg.valid = 0; cfg.index = REG_MAX_DISP; cfg.data = 0;
		result.ready = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: query before any load, extreme slots, extreme coordinates and descriptors.
		send(OP_QUERY, 0, 0, 0, 0);
		send(OP_LOAD_LEFT, 511, 16'hFFFF, 16'hFFFF, '1);
		send(OP_LOAD_RIGHT, 511, 16'hFFFF, 16'hFFFF, '1);
		send(OP_LOAD_LEFT, 0, 16'hFFFF, 16'hFFFF, '1);
		send(OP_LOAD_RIGHT, 0, 16'hFFFF, 16'hFFFF, '0);
		send(OP_QUERY, 0, 0, 0, 0);
		send(OP_QUERY, 511, 0, 0, 0);
		send(OP_NONE, 511, 16'hFFFF, 16'hFFFF, '1);
		send(OP_LOAD_LEFT, 1, 0, 0, '0);
		send(OP_LOAD_RIGHT, 1, 0, 0, '0);
		send(OP_LOAD_RIGHT, 2, 16'd0, 16'd16, '1);
		send(OP_QUERY, 1, 0, 0, 0);
		send(OP_QUERY, 0, 0, 0, 0);
		send(OP_LOAD_RIGHT, 3, 16'd0, 16'd32, 256'h1);
		send(OP_QUERY, 1, 0, 0, 0);
		send(OP_QUERY, 2, 0, 0, 0);
		drain();
		write_reg(REG_MAX_DISP, 8'd0);
		write_reg(REG_MAX_ROW, 8'd0);
		send(OP_LOAD_LEFT, 2, 16'd4096, 16'd800, '0);
		send(OP_LOAD_RIGHT, 4, 16'd4096, 16'd800, 256'h3);
		send(OP_LOAD_RIGHT, 5, 16'd4095, 16'd800, '0);
		send(OP_QUERY, 2, 0, 0, 0);
		send(OP_QUERY, 1, 0, 0, 0);
		send(OP_QUERY, 3, 0, 0, 0);

		// Random scenes across idle modes and window settings.
		scene = 0;
		while (sent_items < TARGET_ITEMS) begin
			drain();
			case (scene % 5)
				0: begin dv = 8'd255; rv = 8'd15; end
				1: begin dv = 8'd0;   rv = 8'd0;  end
				2: begin dv = 8'd40;  rv = 8'd1;  end
				3: begin dv = 8'($urandom); rv = 8'($urandom_range(15)); end
				default: begin dv = 8'd8; rv = 8'd2; end
			endcase
			write_reg(REG_MAX_DISP, dv);
			write_reg(REG_MAX_ROW, rv);
			case ((scene / 2) % 5)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				3: begin send_idle_pct = 29; recv_stall_pct = 29; end
				default: begin
					send_idle_pct = $urandom_range(60); recv_stall_pct = $urandom_range(60);
				end
			endcase
			if (scene == 3) hold_off = 600;
			run_scene($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(4, 14));
			scene++;
		end

		drain();
		if (board.errors == 0 && board.pending_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/shc_pkg.sv
hw/rtl/shc_if.sv
hw/rtl/shc_ram.sv
hw/rtl/shc_scan_unit.sv
hw/rtl/stereo_hamming_cross_check_matcher.sv
tb/tb_top.sv
